// File: rtl/tmp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tmp_pkg;

	// item kinds
	localparam logic [1:0] KIND_STEP  = 2'd0;
	localparam logic [1:0] KIND_SYNC  = 2'd1;
	localparam logic [1:0] KIND_CLEAR = 2'd2;

	// configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_ACCEL = 1'b1;

	// field widths
	localparam int POS_W = 32;
	localparam int LIM_W = 31;
	localparam int DT_W  = 20;

	// register reset values
	localparam logic [LIM_W-1:0] MAX_SPEED_RST = 31'd11796480;
	localparam logic [LIM_W-1:0] MAX_ACCEL_RST = 31'd47185920;

	// snap thresholds and time constants
	localparam logic [32:0] POS_SNAP   = 33'd655;
	localparam logic [31:0] VEL_SNAP   = 32'd6554;
	localparam logic [DT_W-1:0] DEFAULT_US = 20'd1000;

	// shared multiply / divide unit widths
	localparam int MUL_A_W   = 46;
	localparam int MUL_B_W   = 47;
	localparam int PROD_W    = 93;
	localparam int DIV_N_W   = 52;
	localparam int DIV_D_W   = 21;
	localparam int DIV_CNT_W = 6;

	localparam logic [DIV_D_W-1:0] US_PER_S   = 21'd1000000;

	// divide by 1000000 (2000000) as a shift by 6 (7) and a multiply by the
	// reciprocal of 15625, exact for shifted dividends below 2^46
	localparam int US_SH    = 6;
	localparam int RECIP_SH = 60;
	localparam logic [MUL_B_W-1:0] RECIP_15625 = 47'd73786976294839;

	typedef enum logic {
		MD_MUL,
		MD_DIV
	} md_op_t;

	typedef struct packed {
		logic   start;
		md_op_t op;
	} md_req_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_ERR,
		ST_SQ_GO,
		ST_SQ_W,
		ST_BR_GO,
		ST_BR_W,
		ST_VE_GO,
		ST_VE_W,
		ST_AD_GO,
		ST_AD_W,
		ST_AQ_GO,
		ST_AQ_W,
		ST_DVM_GO,
		ST_DVM_W,
		ST_DVD_GO,
		ST_DVD_W,
		ST_D1M_GO,
		ST_D1M_W,
		ST_D1D_GO,
		ST_D1D_W,
		ST_D2M_GO,
		ST_D2M_W,
		ST_D2D_GO,
		ST_D2D_W,
		ST_FIN,
		ST_OUT
	} state_t;

endpackage

`default_nettype wire

// File: rtl/tmp_if.sv
`timescale 1ns / 1ps
`default_nettype none

// command item channel
interface tmp_cmd_if;
	logic                         valid;
	logic                         ready;
	logic [1:0]                   kind;
	logic signed [tmp_pkg::POS_W-1:0] target_pos;
	logic signed [tmp_pkg::POS_W-1:0] measured_pos;
	logic [tmp_pkg::DT_W-1:0]     step_us;

	modport source (output valid, kind, target_pos, measured_pos, step_us, input ready);
	modport sink (input valid, kind, target_pos, measured_pos, step_us, output ready);
endinterface

// result item channel
interface tmp_res_if;
	logic                         valid;
	logic                         ready;
	logic signed [tmp_pkg::POS_W-1:0] planned_pos;
	logic signed [tmp_pkg::POS_W-1:0] planned_speed;
	logic signed [tmp_pkg::POS_W-1:0] planned_accel;
	logic                         ready_res;

	modport source (output valid, planned_pos, planned_speed, planned_accel, ready_res,
		input ready);
	modport sink (input valid, planned_pos, planned_speed, planned_accel, ready_res,
		output ready);
endinterface

// configuration write channel
interface tmp_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [tmp_pkg::CFG_IDX_W-1:0]   index;
	logic [tmp_pkg::LIM_W-1:0]       data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: rtl/tmp_muldiv.sv
`timescale 1ns / 1ps
`default_nettype none

module tmp_muldiv (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire tmp_pkg::md_req_t             req,
	input  wire logic [tmp_pkg::MUL_A_W-1:0]  mul_a,
	input  wire logic [tmp_pkg::MUL_B_W-1:0]  mul_b,
	input  wire logic [tmp_pkg::DIV_N_W-1:0]  div_n,
	input  wire logic [tmp_pkg::DIV_D_W-1:0]  div_d,
	output logic                              done,
	output logic [tmp_pkg::PROD_W-1:0]        prod,
	output logic [tmp_pkg::DIV_N_W-1:0]       quo
);

	logic                             busy_q;
	logic                             done_q;
	tmp_pkg::md_op_t                  op_q;
	logic [tmp_pkg::DIV_CNT_W-1:0]    cnt_q;
	logic [tmp_pkg::PROD_W-1:0]       acc_q;
	logic [tmp_pkg::PROD_W-1:0]       a_q;
	logic [tmp_pkg::MUL_B_W-1:0]      b_q;
	logic [tmp_pkg::DIV_D_W-1:0]      rem_q;
	logic [tmp_pkg::DIV_D_W-1:0]      d_q;
	logic [tmp_pkg::DIV_N_W-1:0]      quo_q;

	logic [tmp_pkg::DIV_D_W:0]        trial;
	logic [tmp_pkg::DIV_D_W:0]        diff;
	logic                             q_bit;
	logic [tmp_pkg::DIV_D_W-1:0]      rem_nx;

	// one restoring divide step
	always_comb begin
		trial  = {rem_q, quo_q[tmp_pkg::DIV_N_W-1]};
		diff   = trial - {1'b0, d_q};
		q_bit  = (trial >= {1'b0, d_q});
		rem_nx = q_bit ? diff[tmp_pkg::DIV_D_W-1:0] : trial[tmp_pkg::DIV_D_W-1:0];
	end

	// sequencing of the unit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			op_q   <= tmp_pkg::MD_MUL;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				op_q   <= req.op;
				cnt_q  <= tmp_pkg::DIV_CNT_W'(tmp_pkg::DIV_N_W);
			end else if (busy_q) begin
				if (op_q == tmp_pkg::MD_MUL) begin
					if (b_q == '0) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
				end else if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// shift-add multiply, one bit a cycle; restoring divide, one bit a cycle
	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= '0;
			a_q   <= {{(tmp_pkg::PROD_W-tmp_pkg::MUL_A_W){1'b0}}, mul_a};
			b_q   <= mul_b;
			rem_q <= '0;
			d_q   <= div_d;
			quo_q <= div_n;
		end else if (busy_q) begin
			if (op_q == tmp_pkg::MD_MUL) begin
				if (b_q[0]) begin
					acc_q <= acc_q + a_q;
				end
				a_q <= a_q << 1;
				b_q <= b_q >> 1;
			end else if (cnt_q != '0) begin
				rem_q <= rem_nx;
				quo_q <= {quo_q[tmp_pkg::DIV_N_W-2:0], q_bit};
			end
		end
	end

	assign done = done_q;
	assign prod = acc_q;
	assign quo  = quo_q;

endmodule

`default_nettype wire

// File: rtl/trapezoid_motion_planner_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// One-axis trapezoidal motion planner, Q16.16 fixed point.
// cmd carries one item: kind (step, sync, clear), target_pos, measured_pos
// and step_us (0 means 1000 us). res returns one item per command: the
// planned position, velocity, acceleration and the initialized flag.
// cfg writes max_speed (index 0) and max_accel (index 1); it is always ready
// and must be written only while the planner is idle; the block itself does not enforce this.
// Sync, clear and unused kinds go from idle straight to the output state. A
// step that snaps to rest goes from the error state to the output state; a
// full step runs up to seven shift-add multiplies, three reciprocal
// multiplies for the divisions by one and two million and one restoring
// divide by the time step on one shared unit. cmd.ready is high only while
// the sequencer is idle, so one item is in work at once.
// The result sits in an output register: the sequencer goes back to idle
// and takes the next item while a result waits; a finished second item then
// waits until the receiver takes the first.
// Reset clears position, velocity, acceleration and the initialized flag,
// loads the default limits and drops res.valid.

module trapezoid_motion_planner_unit (
	input  wire logic     clk,
	input  wire logic     arst_n,
	tmp_cmd_if.sink       cmd,
	tmp_res_if.source     res,
	tmp_cfg_if.sink       cfg
);

	tmp_pkg::state_t state_q, state_nx;

	logic [tmp_pkg::LIM_W-1:0]        max_speed_q;
	logic [tmp_pkg::LIM_W-1:0]        max_accel_q;
	logic signed [31:0]               pos_q;
	logic signed [31:0]               spd_q;
	logic signed [31:0]               acc_q;
	logic                             init_q;

	logic signed [31:0]               tgt_q;
	logic [tmp_pkg::DT_W-1:0]         dt_q;
	logic [32:0]                      aerr_q;
	logic                             dirp_q;
	logic                             dirn_q;
	logic [63:0]                      sq_q;
	logic signed [32:0]               verr_q;
	logic [tmp_pkg::DIV_N_W-1:0]      vnum_q;
	logic signed [31:0]               accw_q;
	logic signed [32:0]               dv_q;
	logic signed [35:0]               np_q;
	logic signed [32:0]               d2_q;

	logic                             res_valid_q;
	logic signed [31:0]               res_pos_q;
	logic signed [31:0]               res_spd_q;
	logic signed [31:0]               res_acc_q;
	logic                             res_init_q;

	tmp_pkg::md_req_t                 md_req;
	logic [tmp_pkg::MUL_A_W-1:0]      mul_a;
	logic [tmp_pkg::MUL_B_W-1:0]      mul_b;
	logic [tmp_pkg::DIV_N_W-1:0]      div_n;
	logic [tmp_pkg::DIV_D_W-1:0]      div_d;
	logic                             md_done;
	logic [tmp_pkg::PROD_W-1:0]       md_prod;
	logic [tmp_pkg::DIV_N_W-1:0]      md_quo;

	logic                             cmd_acc;
	logic                             out_free;
	logic [tmp_pkg::LIM_W-1:0]        amax;
	logic [31:0]                      av;
	logic signed [32:0]               err;
	logic [32:0]                      aerr;
	logic                             snap;
	logic                             brake;
	logic signed [32:0]               vmax33;
	logic signed [32:0]               spd33;
	logic signed [32:0]               verr_nx;
	logic [32:0]                      averr;
	logic [31:0]                      aaccw;
	logic [32:0]                      adv;
	logic [32:0]                      q33;
	logic signed [32:0]               q33_neg;
	logic signed [32:0]               d1;
	logic signed [33:0]               nv_sum;
	logic signed [33:0]               vmax34;
	logic signed [33:0]               nv_cl;
	logic                             rev;
	logic signed [35:0]               np_fin;
	logic signed [36:0]               tdiff;
	logic                             over;
	logic signed [31:0]               np_sat;

	assign cmd_acc  = cmd.valid && cmd.ready;
	assign out_free = !res_valid_q || res.ready;

	// common datapath terms
	always_comb begin
		amax    = (max_accel_q == '0) ? tmp_pkg::LIM_W'(1) : max_accel_q;
		av      = spd_q[31] ? 32'(-spd_q) : 32'(spd_q);
		err     = 33'(tgt_q) - 33'(pos_q);
		aerr    = err[32] ? 33'(-err) : 33'(err);
		snap    = (aerr <= tmp_pkg::POS_SNAP) && (av <= tmp_pkg::VEL_SNAP);
		brake   = (md_prod <= tmp_pkg::PROD_W'(sq_q)) && (spd_q != '0);
		vmax33  = {2'b00, max_speed_q};
		spd33   = 33'(spd_q);
		verr_nx = dirp_q ? (vmax33 - spd33) : (-vmax33 - spd33);
		averr   = verr_q[32] ? 33'(-verr_q) : 33'(verr_q);
		aaccw   = accw_q[31] ? 32'(-accw_q) : 32'(accw_q);
		adv     = dv_q[32] ? 33'(-dv_q) : 33'(dv_q);
		q33     = md_prod[tmp_pkg::PROD_W-1:tmp_pkg::RECIP_SH];
		q33_neg = -$signed(q33);
		d1      = spd_q[31] ? q33_neg : $signed(q33);
	end

	// final velocity and position
	always_comb begin
		nv_sum = 34'(spd_q) + 34'(dv_q);
		vmax34 = {3'b000, max_speed_q};
		if (nv_sum > vmax34) begin
			nv_cl = vmax34;
		end else if (nv_sum < -vmax34) begin
			nv_cl = -vmax34;
		end else begin
			nv_cl = nv_sum;
		end
		rev    = ((spd_q > 0) && (nv_cl < 0)) || ((spd_q < 0) && (nv_cl > 0));
		np_fin = np_q + 36'(d2_q);
		tdiff  = 37'(tgt_q) - 37'(np_fin);
		over   = (dirp_q && (tdiff <= 0)) || (dirn_q && (tdiff >= 0));
		if (np_fin > 36'sh07FFFFFFF) begin
			np_sat = 32'sh7FFFFFFF;
		end else if (np_fin < -36'sh080000000) begin
			np_sat = 32'sh80000000;
		end else begin
			np_sat = np_fin[31:0];
		end
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			tmp_pkg::ST_IDLE: begin
				if (cmd_acc) begin
					state_nx = (cmd.kind == tmp_pkg::KIND_STEP) ? tmp_pkg::ST_ERR
						: tmp_pkg::ST_OUT;
				end
			end
			tmp_pkg::ST_ERR:    state_nx = snap ? tmp_pkg::ST_OUT : tmp_pkg::ST_SQ_GO;
			tmp_pkg::ST_SQ_GO:  state_nx = tmp_pkg::ST_SQ_W;
			tmp_pkg::ST_SQ_W:   if (md_done) state_nx = tmp_pkg::ST_BR_GO;
			tmp_pkg::ST_BR_GO:  state_nx = tmp_pkg::ST_BR_W;
			tmp_pkg::ST_BR_W: begin
				if (md_done) begin
					state_nx = (!brake && (dirp_q || dirn_q)) ? tmp_pkg::ST_VE_GO
						: tmp_pkg::ST_DVM_GO;
				end
			end
			tmp_pkg::ST_VE_GO:  state_nx = tmp_pkg::ST_VE_W;
			tmp_pkg::ST_VE_W:   if (md_done) state_nx = tmp_pkg::ST_AD_GO;
			tmp_pkg::ST_AD_GO:  state_nx = tmp_pkg::ST_AD_W;
			tmp_pkg::ST_AD_W: begin
				if (md_done) begin
					state_nx = (tmp_pkg::PROD_W'(vnum_q) <= md_prod) ? tmp_pkg::ST_AQ_GO
						: tmp_pkg::ST_DVM_GO;
				end
			end
			tmp_pkg::ST_AQ_GO:  state_nx = tmp_pkg::ST_AQ_W;
			tmp_pkg::ST_AQ_W:   if (md_done) state_nx = tmp_pkg::ST_DVM_GO;
			tmp_pkg::ST_DVM_GO: state_nx = tmp_pkg::ST_DVM_W;
			tmp_pkg::ST_DVM_W:  if (md_done) state_nx = tmp_pkg::ST_DVD_GO;
			tmp_pkg::ST_DVD_GO: state_nx = tmp_pkg::ST_DVD_W;
			tmp_pkg::ST_DVD_W:  if (md_done) state_nx = tmp_pkg::ST_D1M_GO;
			tmp_pkg::ST_D1M_GO: state_nx = tmp_pkg::ST_D1M_W;
			tmp_pkg::ST_D1M_W:  if (md_done) state_nx = tmp_pkg::ST_D1D_GO;
			tmp_pkg::ST_D1D_GO: state_nx = tmp_pkg::ST_D1D_W;
			tmp_pkg::ST_D1D_W:  if (md_done) state_nx = tmp_pkg::ST_D2M_GO;
			tmp_pkg::ST_D2M_GO: state_nx = tmp_pkg::ST_D2M_W;
			tmp_pkg::ST_D2M_W:  if (md_done) state_nx = tmp_pkg::ST_D2D_GO;
			tmp_pkg::ST_D2D_GO: state_nx = tmp_pkg::ST_D2D_W;
			tmp_pkg::ST_D2D_W:  if (md_done) state_nx = tmp_pkg::ST_FIN;
			tmp_pkg::ST_FIN:    state_nx = tmp_pkg::ST_OUT;
			tmp_pkg::ST_OUT:    if (out_free) state_nx = tmp_pkg::ST_IDLE;
			default:            state_nx = tmp_pkg::ST_IDLE;
		endcase
	end

	// unit requests and operands
	always_comb begin
		md_req.start = 1'b0;
		md_req.op    = tmp_pkg::MD_MUL;
		mul_a        = '0;
		mul_b        = '0;
		div_n        = md_prod[tmp_pkg::DIV_N_W-1:0];
		div_d        = tmp_pkg::US_PER_S;
		unique case (state_q)
			tmp_pkg::ST_SQ_GO: begin
				md_req.start = 1'b1;
				mul_a        = tmp_pkg::MUL_A_W'(av);
				mul_b        = tmp_pkg::MUL_B_W'(av);
			end
			tmp_pkg::ST_BR_GO: begin
				md_req.start = 1'b1;
				mul_a        = tmp_pkg::MUL_A_W'(aerr_q);
				mul_b        = tmp_pkg::MUL_B_W'({amax, 1'b0});
			end
			tmp_pkg::ST_VE_GO: begin
				md_req.start = 1'b1;
				mul_a        = tmp_pkg::MUL_A_W'(averr);
				mul_b        = tmp_pkg::MUL_B_W'(tmp_pkg::US_PER_S);
			end
			tmp_pkg::ST_AD_GO: begin
				md_req.start = 1'b1;
				mul_a        = tmp_pkg::MUL_A_W'(amax);
				mul_b        = tmp_pkg::MUL_B_W'(dt_q);
			end
			tmp_pkg::ST_AQ_GO: begin
				md_req.start = 1'b1;
				md_req.op    = tmp_pkg::MD_DIV;
				div_n        = vnum_q;
				div_d        = 21'(dt_q);
			end
			tmp_pkg::ST_DVM_GO: begin
				md_req.start = 1'b1;
				mul_a        = tmp_pkg::MUL_A_W'(aaccw);
				mul_b        = tmp_pkg::MUL_B_W'(dt_q);
			end
			tmp_pkg::ST_D1M_GO: begin
				md_req.start = 1'b1;
				mul_a        = tmp_pkg::MUL_A_W'(av);
				mul_b        = tmp_pkg::MUL_B_W'(dt_q);
			end
			tmp_pkg::ST_D2M_GO: begin
				md_req.start = 1'b1;
				mul_a        = tmp_pkg::MUL_A_W'(adv);
				mul_b        = tmp_pkg::MUL_B_W'(dt_q);
			end
			// divide by one million through the reciprocal
			tmp_pkg::ST_DVD_GO, tmp_pkg::ST_D1D_GO: begin
				md_req.start = 1'b1;
				mul_a        = md_prod[tmp_pkg::DIV_N_W-1:tmp_pkg::US_SH];
				mul_b        = tmp_pkg::RECIP_15625;
			end
			// divide by two million through the reciprocal
			tmp_pkg::ST_D2D_GO: begin
				md_req.start = 1'b1;
				mul_a        = {1'b0, md_prod[tmp_pkg::DIV_N_W-1:tmp_pkg::US_SH+1]};
				mul_b        = tmp_pkg::RECIP_15625;
			end
			default: begin
				md_req.start = 1'b0;
			end
		endcase
	end

	assign cmd.ready = (state_q == tmp_pkg::ST_IDLE);
	assign cfg.ready = 1'b1;

	// sequencer, planner state and limits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tmp_pkg::ST_IDLE;
			max_speed_q <= tmp_pkg::MAX_SPEED_RST;
			max_accel_q <= tmp_pkg::MAX_ACCEL_RST;
			pos_q       <= '0;
			spd_q       <= '0;
			acc_q       <= '0;
			init_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cfg.valid) begin
				if (cfg.index == tmp_pkg::CFG_MAX_SPEED) begin
					max_speed_q <= cfg.data;
				end else begin
					max_accel_q <= cfg.data;
				end
			end
			// output register valid
			if (state_q == tmp_pkg::ST_OUT && out_free) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				tmp_pkg::ST_IDLE: begin
					if (cmd_acc) begin
						if (cmd.kind == tmp_pkg::KIND_SYNC
							|| (cmd.kind == tmp_pkg::KIND_STEP && !init_q)) begin
							pos_q  <= cmd.measured_pos;
							spd_q  <= '0;
							acc_q  <= '0;
							init_q <= 1'b1;
						end else if (cmd.kind == tmp_pkg::KIND_CLEAR) begin
							pos_q  <= '0;
							spd_q  <= '0;
							acc_q  <= '0;
							init_q <= 1'b0;
						end
					end
				end
				tmp_pkg::ST_ERR: begin
					if (snap) begin
						pos_q <= tgt_q;
						spd_q <= '0;
						acc_q <= '0;
					end
				end
				tmp_pkg::ST_FIN: begin
					if (over) begin
						pos_q <= tgt_q;
						spd_q <= '0;
						acc_q <= '0;
					end else begin
						pos_q <= np_sat;
						spd_q <= rev ? 32'sd0 : nv_cl[31:0];
						acc_q <= accw_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// working registers of one step
	always_ff @(posedge clk) begin
		unique case (state_q)
			tmp_pkg::ST_IDLE: begin
				if (cmd_acc) begin
					tgt_q <= cmd.target_pos;
					dt_q  <= (cmd.step_us == '0) ? tmp_pkg::DEFAULT_US : cmd.step_us;
				end
			end
			tmp_pkg::ST_ERR: begin
				aerr_q <= aerr;
				dirp_q <= !err[32] && (err != '0);
				dirn_q <= err[32];
			end
			tmp_pkg::ST_SQ_W: begin
				if (md_done) sq_q <= md_prod[63:0];
			end
			tmp_pkg::ST_BR_W: begin
				if (md_done) begin
					verr_q <= verr_nx;
					if (brake) begin
						accw_q <= spd_q[31] ? 32'(amax) : -32'(amax);
					end else begin
						accw_q <= '0;
					end
				end
			end
			tmp_pkg::ST_VE_W: begin
				if (md_done) vnum_q <= md_prod[tmp_pkg::DIV_N_W-1:0];
			end
			tmp_pkg::ST_AD_W: begin
				if (md_done) accw_q <= dirp_q ? 32'(amax) : -32'(amax);
			end
			tmp_pkg::ST_AQ_W: begin
				if (md_done) begin
					accw_q <= verr_q[32] ? -md_quo[31:0] : md_quo[31:0];
				end
			end
			tmp_pkg::ST_DVD_W: begin
				if (md_done) dv_q <= accw_q[31] ? q33_neg : $signed(q33);
			end
			tmp_pkg::ST_D1D_W: begin
				if (md_done) np_q <= 36'(pos_q) + 36'(d1);
			end
			tmp_pkg::ST_D2D_W: begin
				if (md_done) d2_q <= dv_q[32] ? q33_neg : $signed(q33);
			end
			tmp_pkg::ST_OUT: begin
				if (out_free) begin
					res_pos_q  <= pos_q;
					res_spd_q  <= spd_q;
					res_acc_q  <= acc_q;
					res_init_q <= init_q;
				end
			end
			default: begin
			end
		endcase
	end

	tmp_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (md_req),
		.mul_a  (mul_a),
		.mul_b  (mul_b),
		.div_n  (div_n),
		.div_d  (div_d),
		.done   (md_done),
		.prod   (md_prod),
		.quo    (md_quo)
	);

	assign res.valid         = res_valid_q;
	assign res.planned_pos   = res_pos_q;
	assign res.planned_speed = res_spd_q;
	assign res.planned_accel = res_acc_q;
	assign res.ready_res     = res_init_q;

endmodule

`default_nettype wire

// File: rtl/tmp_sva.sv
`timescale 1ns / 1ps
`default_nettype none

module tmp_sva (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        cmd_valid,
	input wire logic        cmd_ready,
	input wire logic        res_valid,
	input wire logic        res_ready,
	input wire logic [31:0] res_pos,
	input wire logic [31:0] res_speed,
	input wire logic [31:0] res_accel,
	input wire logic        res_init
);

	// a stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_pos)
			&& $stable(res_speed) && $stable(res_accel) && $stable(res_init))
		else $error("stalled result changed");

	// one item in work at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("item taken while busy");

	// a new result comes only out of a busy cycle
	a_rose: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(!cmd_ready))
		else $error("result without work");

	// an uninitialized planner reports all zero
	a_uninit: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_init |-> res_pos == '0 && res_speed == '0 && res_accel == '0)
		else $error("uninitialized state not zero");

endmodule

bind trapezoid_motion_planner_unit tmp_sva u_tmp_sva (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd.valid),
	.cmd_ready (cmd.ready),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.res_pos   (res.planned_pos),
	.res_speed (res.planned_speed),
	.res_accel (res.planned_accel),
	.res_init  (res.ready_res)
);

`default_nettype wire
